// ----- rtl/smcp_pkg.sv -----
package smcp_pkg;

  // Result command codes
  typedef enum logic [2:0] {
    CMD_FWD     = 3'd0,
    CMD_BACK    = 3'd1,
    CMD_LEFT    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_DIFF    = 3'd5,
    CMD_ENCODER = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_t;

  // Number parser phases (atoi-like)
  typedef enum logic [1:0] {
    PH_WS     = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  localparam int unsigned MAG_W     = 15;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 15'd32767;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Queue between classifier and parser
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;

  // Classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_nl;
    logic       is_nul;
    logic       is_ws;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic       is_comma;
    logic       is_colon;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    phase_t           phase;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } num_t;

  localparam num_t NUM_CLEAR = '{phase: PH_WS, negative: 1'b0, magnitude: '0};

  // One byte of an atoi-style number parse
  function automatic num_t num_feed(num_t p, token_t t);
    num_t        n;
    logic [18:0] m;
    n = p;
    m = {1'b0, p.magnitude, 3'b000} + {3'b000, p.magnitude, 1'b0} + {15'd0, t.digit};
    if (p.phase == PH_WS && t.is_ws) begin
      n = p;
    end else if (p.phase == PH_WS && t.is_sign) begin
      n.negative = t.is_minus;
      n.phase    = PH_SIGN;
    end else if (p.phase == PH_DONE) begin
      n = p;
    end else if (t.is_digit) begin
      n.magnitude = (m > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : m[MAG_W-1:0];
      n.phase     = PH_DIGITS;
    end else begin
      n.phase = PH_DONE;
    end
    return n;
  endfunction

  function automatic logic [VAL_W-1:0] num_value(num_t p);
    logic [VAL_W-1:0] v;
    v = {1'b0, p.magnitude};
    return p.negative ? (~v + 16'd1) : v;
  endfunction

endpackage

// ----- rtl/smcp_front.sv -----
module smcp_front (
  input  logic                 s_tvalid,
  input  logic [7:0]           s_tdata,
  input  logic                 q_full,
  output logic                 s_tready,
  output logic                 push,
  output smcp_pkg::token_t     token
);

  logic [7:0] c;
  assign c = s_tdata;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    token          = '0;
    token.data     = c;
    token.is_nl    = (c == smcp_pkg::CH_NL);
    token.is_nul   = (c == smcp_pkg::CH_NUL);
    token.is_ws    = (c == smcp_pkg::CH_SPACE) ||
                     (c >= smcp_pkg::CH_TAB && c <= smcp_pkg::CH_CR);
    token.is_digit = (c >= smcp_pkg::CH_ZERO && c <= smcp_pkg::CH_NINE);
    token.is_minus = (c == smcp_pkg::CH_MINUS);
    token.is_sign  = (c == smcp_pkg::CH_PLUS) || token.is_minus;
    token.is_comma = (c == smcp_pkg::CH_COMMA);
    token.is_colon = (c == smcp_pkg::CH_COLON);
    token.digit    = token.is_digit ? c[3:0] : 4'd0;
  end

endmodule

// ----- rtl/smcp_queue.sv -----
module smcp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  smcp_pkg::token_t wr_token,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output smcp_pkg::token_t rd_token
);

  smcp_pkg::token_t entries [smcp_pkg::Q_DEPTH];
  logic [smcp_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [smcp_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [smcp_pkg::Q_CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == smcp_pkg::Q_CNT_W'(smcp_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_token  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/smcp_back.sv -----
module smcp_back #(
  parameter int unsigned LINE_BUFFER_BYTES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tok_valid,
  input  smcp_pkg::token_t                   tok,
  output logic                               tok_pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [smcp_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                         m_tuser
);

  localparam int unsigned LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUFFER_BYTES - 1);

  // line state
  logic [LEN_W-1:0]  line_length, line_length_next;
  logic [7:0]        first_byte, first_byte_next;
  logic              colon_second, colon_second_next;
  logic              text_ended, text_ended_next;
  logic              comma_seen, comma_seen_next;
  smcp_pkg::num_t    first_num, first_num_next;
  smcp_pkg::num_t    second_num, second_num_next;

  // result
  smcp_pkg::cmd_t    cmd;
  logic [15:0]       v1, v2;
  logic              emit;
  logic              take;
  logic [smcp_pkg::OUT_DATA_W-1:0] out_data;

  // a newline needs room in the output register
  assign take    = tok_valid && (!tok.is_nl || !m_tvalid || m_tready);
  assign tok_pop = take;

  // line-end decode
  always_comb begin
    logic speed_cmd;
    cmd       = smcp_pkg::CMD_UNKNOWN;
    v1        = '0;
    v2        = '0;
    emit      = 1'b1;
    speed_cmd = 1'b0;
    if (first_byte == smcp_pkg::CH_F && colon_second) begin
      cmd = smcp_pkg::CMD_FWD;   speed_cmd = 1'b1;
    end else if (first_byte == smcp_pkg::CH_B && colon_second) begin
      cmd = smcp_pkg::CMD_BACK;  speed_cmd = 1'b1;
    end else if (first_byte == smcp_pkg::CH_L && colon_second) begin
      cmd = smcp_pkg::CMD_LEFT;  speed_cmd = 1'b1;
    end else if (first_byte == smcp_pkg::CH_R && colon_second) begin
      cmd = smcp_pkg::CMD_RIGHT; speed_cmd = 1'b1;
    end else if (first_byte == smcp_pkg::CH_S) begin
      cmd = smcp_pkg::CMD_STOP;
    end else if (first_byte == smcp_pkg::CH_D && colon_second) begin
      if (comma_seen) begin
        cmd = smcp_pkg::CMD_DIFF;
        v1  = smcp_pkg::num_value(first_num);
        v2  = smcp_pkg::num_value(second_num);
      end else begin
        emit = 1'b0;
      end
    end else if (first_byte == smcp_pkg::CH_E) begin
      cmd = smcp_pkg::CMD_ENCODER;
    end
    // negative speed is clamped to zero
    if (speed_cmd && !first_num.negative) begin
      v1 = {1'b0, first_num.magnitude};
    end
  end

  assign out_data = {v2, v1};

  // per-byte line update
  always_comb begin
    logic clear;
    line_length_next  = line_length;
    first_byte_next   = first_byte;
    colon_second_next = colon_second;
    text_ended_next   = text_ended;
    comma_seen_next   = comma_seen;
    first_num_next    = first_num;
    second_num_next   = second_num;
    clear             = 1'b0;
    if (take) begin
      if (tok.is_nl) begin
        clear = 1'b1;
      end else begin
        if (!text_ended) begin
          if (tok.is_nul) begin
            text_ended_next = 1'b1;
          end else if (line_length == '0) begin
            first_byte_next = tok.data;
          end else if (line_length == LEN_W'(1)) begin
            colon_second_next = tok.is_colon;
          end else begin
            first_num_next = smcp_pkg::num_feed(first_num, tok);
            if (comma_seen) begin
              second_num_next = smcp_pkg::num_feed(second_num, tok);
            end else if (tok.is_comma) begin
              comma_seen_next = 1'b1;
            end
          end
        end
        // buffer full: line restarts empty
        if (line_length == LEN_LAST) begin
          clear = 1'b1;
        end else begin
          line_length_next = line_length + 1'b1;
        end
      end
    end
    if (clear) begin
      line_length_next  = '0;
      first_byte_next   = '0;
      colon_second_next = 1'b0;
      text_ended_next   = 1'b0;
      comma_seen_next   = 1'b0;
      first_num_next    = smcp_pkg::NUM_CLEAR;
      second_num_next   = smcp_pkg::NUM_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      first_byte   <= '0;
      colon_second <= 1'b0;
      text_ended   <= 1'b0;
      comma_seen   <= 1'b0;
      first_num    <= smcp_pkg::NUM_CLEAR;
      second_num   <= smcp_pkg::NUM_CLEAR;
    end else begin
      line_length  <= line_length_next;
      first_byte   <= first_byte_next;
      colon_second <= colon_second_next;
      text_ended   <= text_ended_next;
      comma_seen   <= comma_seen_next;
      first_num    <= first_num_next;
      second_num   <= second_num_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && tok.is_nl && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.is_nl && emit) begin
      m_tdata <= out_data;
      m_tuser <= cmd;
    end
  end

endmodule

// ----- rtl/serial_motion_command_parser_top.sv -----
// Serial motion command parser.
// Slave side (s_tvalid/s_tready/s_tdata) takes one received serial byte per
// word; byte 0x0A ends a line. Master side (m_tvalid/m_tready/m_tdata/m_tuser)
// gives one command word per completed line that decodes to a result: speed
// commands F:/B:/L:/R:, stop (S), differential drive (D:a,b), encoder
// query (E) or unknown. m_tuser carries the command code, m_tdata the values.
// A D: line without a comma gives no word.
// Throughput: one byte per cycle while s_tready is high. The classifier
// pushes into a 4-entry queue; the parser pops one byte per cycle (not a
// newline while a word waits) and updates its line state. A newline goes
// through the queue into the output register that raises m_tvalid.
// Stall: when m_tready is low and a word is held, the parser stops only on
// the next newline; the queue then fills with that newline and the three
// bytes behind it, and s_tready drops. Bytes ahead of that newline keep
// flowing while a word waits.
// Reset (rst, synchronous, active high) empties the queue, drops m_tvalid
// and returns the line state to empty.
// Lines that reach LINE_BUFFER_BYTES bytes restart empty.
module serial_motion_command_parser_top #(
  parameter int unsigned LINE_BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] first_value, [31:16] second_value
  output logic [2:0]  m_tuser    // [2:0] command
);

  logic             q_full;
  logic             q_not_empty;
  logic             push;
  logic             pop;
  smcp_pkg::token_t wr_token;
  smcp_pkg::token_t rd_token;

  // front: handshake and byte classification
  smcp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .s_tready (s_tready),
    .push     (push),
    .token    (wr_token)
  );

  // decoupling queue
  smcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_token  (wr_token),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_token  (rd_token)
  );

  // back: line parser and output register
  smcp_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_not_empty),
    .tok       (rd_token),
    .tok_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- bench/smcp_command_checker.sv -----
`timescale 1ns / 1ps

module smcp_command_checker #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [15:0] first_value, [31:16] second_value
  input  logic [2:0]  m_tuser,   // [2:0] command
  output int          errors,
  output int          pending
);

  typedef struct {
    smcp_pkg::phase_t phase;
    logic             neg;
    logic [14:0]      mag;
  } atoi_state_t;

  typedef struct {
    smcp_pkg::cmd_t cmd;
    logic [15:0]    v1;
    logic [15:0]    v2;
  } motion_cmd_t;

  motion_cmd_t queued_commands[$];

  int unsigned line_len;
  logic [7:0]  lead_byte;
  logic        colon_at_1;
  logic        text_done;
  logic        comma_found;
  atoi_state_t lin_num;
  atoi_state_t ang_num;
  int          fail_count = 0;
  int          queued_count = 0;

  assign errors  = fail_count;
  assign pending = queued_count;

  // one character through an atoi-style number scan
  function automatic atoi_state_t atoi_step(atoi_state_t st, logic [7:0] c);
    atoi_state_t nx;
    logic [18:0] prod;
    nx = st;
    if (st.phase == smcp_pkg::PH_WS && (c == smcp_pkg::CH_SPACE ||
        (c >= smcp_pkg::CH_TAB && c <= smcp_pkg::CH_CR)))
      return nx;
    if (st.phase == smcp_pkg::PH_WS &&
        (c == smcp_pkg::CH_PLUS || c == smcp_pkg::CH_MINUS)) begin
      nx.neg   = (c == smcp_pkg::CH_MINUS);
      nx.phase = smcp_pkg::PH_SIGN;
      return nx;
    end
    if (st.phase == smcp_pkg::PH_DONE)
      return nx;
    if (c >= smcp_pkg::CH_ZERO && c <= smcp_pkg::CH_NINE) begin
      prod     = 19'(st.mag) * 19'd10 + 19'(c - smcp_pkg::CH_ZERO);
      nx.mag   = (prod > 19'd32767) ? 15'h7FFF : prod[14:0];
      nx.phase = smcp_pkg::PH_DIGITS;
    end else begin
      nx.phase = smcp_pkg::PH_DONE;
    end
    return nx;
  endfunction

  function automatic logic [15:0] atoi_value(atoi_state_t st);
    logic [15:0] u;
    u = {1'b0, st.mag};
    return st.neg ? (16'd0 - u) : u;
  endfunction

  task automatic clear_line();
    line_len    = 0;
    lead_byte   = 8'd0;
    colon_at_1  = 1'b0;
    text_done   = 1'b0;
    comma_found = 1'b0;
    lin_num     = '{smcp_pkg::PH_WS, 1'b0, 15'd0};
    ang_num     = '{smcp_pkg::PH_WS, 1'b0, 15'd0};
  endtask

  task automatic predict_byte(logic [7:0] c);
    motion_cmd_t r;
    logic        emit;
    if (c == smcp_pkg::CH_NL) begin
      r    = '{smcp_pkg::CMD_UNKNOWN, 16'd0, 16'd0};
      emit = 1'b1;
      if (colon_at_1 && (lead_byte == smcp_pkg::CH_F || lead_byte == smcp_pkg::CH_B ||
                         lead_byte == smcp_pkg::CH_L || lead_byte == smcp_pkg::CH_R)) begin
        case (lead_byte)
          smcp_pkg::CH_F: r.cmd = smcp_pkg::CMD_FWD;
          smcp_pkg::CH_B: r.cmd = smcp_pkg::CMD_BACK;
          smcp_pkg::CH_L: r.cmd = smcp_pkg::CMD_LEFT;
          default:        r.cmd = smcp_pkg::CMD_RIGHT;
        endcase
        // negative speed clamps to zero
        r.v1 = lin_num.neg ? 16'd0 : {1'b0, lin_num.mag};
      end else if (lead_byte == smcp_pkg::CH_S) begin
        r.cmd = smcp_pkg::CMD_STOP;
      end else if (lead_byte == smcp_pkg::CH_D && colon_at_1) begin
        if (comma_found) begin
          r.cmd = smcp_pkg::CMD_DIFF;
          r.v1  = atoi_value(lin_num);
          r.v2  = atoi_value(ang_num);
        end else begin
          emit = 1'b0;
        end
      end else if (lead_byte == smcp_pkg::CH_E) begin
        r.cmd = smcp_pkg::CMD_ENCODER;
      end
      clear_line();
      if (emit)
        queued_commands.push_back(r);
    end else begin
      if (!text_done) begin
        if (c == smcp_pkg::CH_NUL) begin
          text_done = 1'b1;
        end else if (line_len == 0) begin
          lead_byte = c;
        end else if (line_len == 1) begin
          colon_at_1 = (c == smcp_pkg::CH_COLON);
        end else begin
          lin_num = atoi_step(lin_num, c);
          if (comma_found)
            ang_num = atoi_step(ang_num, c);
          else if (c == smcp_pkg::CH_COMMA)
            comma_found = 1'b1;
        end
      end
      line_len++;
      if (line_len >= LINE_BYTES)
        clear_line();
    end
  endtask

  always @(posedge clk) begin
    motion_cmd_t exp_cmd;
    if (rst) begin
      clear_line();
      queued_commands.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (queued_commands.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual cmd=%0d data=%h",
                   $time, m_tuser, m_tdata);
        end else begin
          exp_cmd = queued_commands.pop_front();
          if (m_tuser !== exp_cmd.cmd || m_tdata[15:0] !== exp_cmd.v1 ||
              m_tdata[31:16] !== exp_cmd.v2) begin
            fail_count++;
            $display("%0t: mismatch, expected cmd=%0d a=%0d b=%0d, %s",
                     $time, exp_cmd.cmd, $signed(exp_cmd.v1), $signed(exp_cmd.v2),
                     $sformatf("actual cmd=%0d a=%0d b=%0d", m_tuser,
                               $signed(m_tdata[15:0]), $signed(m_tdata[31:16])));
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_byte(s_tdata);
    end
    queued_count = queued_commands.size();
  end

endmodule

// ----- bench/tb_serial_motion_command_parser_top.sv -----
`timescale 1ns / 1ps

module tb_serial_motion_command_parser_top;

  localparam int unsigned LINE_BYTES = 64;
  localparam int RANDOM_BYTES = 1450;
  // one long receiver hold-off; must stay well below the watchdog limit
  localparam int HOLD_CYCLES  = 400;
  // quiet cycles allowed: hold-off plus worst idle bursts on both sides
  localparam int QUIET_LIMIT  = 3000;
  // covers the parser queue depth plus the pipeline
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  int          errors;
  int          pending;

  // bytes of the line being built for the sender
  logic [7:0]  line_bytes[$];
  int          bytes_sent;
  int          quiet_cycles;
  int          hold_left;
  logic        idle_on;
  logic        hold_off_req;
  logic        hold_done;

  serial_motion_command_parser_top #(
    .LINE_BUFFER_BYTES (LINE_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  smcp_command_checker #(
    .LINE_BYTES (LINE_BYTES)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void put_str(string s);
    foreach (s[i])
      line_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 6))
      0:       return smcp_pkg::CH_F;
      1:       return smcp_pkg::CH_B;
      2:       return smcp_pkg::CH_L;
      3:       return smcp_pkg::CH_R;
      4:       return smcp_pkg::CH_D;
      5:       return smcp_pkg::CH_S;
      default: return smcp_pkg::CH_E;
    endcase
  endfunction

  // atoi text: optional whitespace, optional sign, digits, maybe trailing junk
  function automatic void put_number();
    int n_ws;
    int n_dig;
    n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n_ws) begin
      case ($urandom_range(0, 4))
        0:       line_bytes.push_back(smcp_pkg::CH_TAB);
        1:       line_bytes.push_back(8'h0B);
        2:       line_bytes.push_back(8'h0C);
        3:       line_bytes.push_back(smcp_pkg::CH_CR);
        default: line_bytes.push_back(smcp_pkg::CH_SPACE);
      endcase
    end
    case ($urandom_range(0, 3))
      0:       line_bytes.push_back(smcp_pkg::CH_PLUS);
      1:       line_bytes.push_back(smcp_pkg::CH_MINUS);
      default: ;
    endcase
    // mostly short numbers, some long enough to saturate
    n_dig = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
    repeat (n_dig)
      line_bytes.push_back(smcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 7) == 0)
      line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
  endfunction

  function automatic void build_line();
    int         sel;
    int         n;
    logic [7:0] lead;
    line_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 72 || (sel >= 88 && sel < 96)) begin
      // well-formed command, random content
      lead = pick_letter();
      line_bytes.push_back(lead);
      if (lead == smcp_pkg::CH_S || lead == smcp_pkg::CH_E) begin
        if ($urandom_range(0, 1)) begin
          line_bytes.push_back(smcp_pkg::CH_COLON);
          put_number();
        end
      end else begin
        if ($urandom_range(0, 15) != 0)
          line_bytes.push_back(smcp_pkg::CH_COLON);
        else
          line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        put_number();
        if (lead == smcp_pkg::CH_D && $urandom_range(0, 7) != 0) begin
          line_bytes.push_back(smcp_pkg::CH_COMMA);
          put_number();
          if ($urandom_range(0, 4) == 0) begin
            line_bytes.push_back(smcp_pkg::CH_COMMA);
            put_number();
          end
        end
      end
      // zero byte dropped somewhere into the text
      if (sel >= 88)
        line_bytes.insert($urandom_range(0, line_bytes.size()), smcp_pkg::CH_NUL);
    end else if (sel < 80) begin
      // arbitrary lead byte
      line_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1))
        line_bytes.push_back(smcp_pkg::CH_COLON);
      put_number();
    end else if (sel < 88) begin
      // raw noise, any byte value
      n = $urandom_range(0, 12);
      repeat (n)
        line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // runs near or past the line buffer
      line_bytes.push_back(pick_letter());
      line_bytes.push_back(smcp_pkg::CH_COLON);
      n = $urandom_range(56, 72);
      repeat (n)
        line_bytes.push_back(($urandom_range(0, 3) == 0) ? smcp_pkg::CH_SPACE :
                             smcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    line_bytes.push_back(smcp_pkg::CH_NL);
  endfunction

  // offer one word, with an occasional idle burst first
  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i])
      send_byte(line_bytes[i]);
  endtask

  task automatic send_text(string s);
    line_bytes.delete();
    put_str(s);
    send_line();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    idle_on      = 1'b1;
    bytes_sent   = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: each command, signs, saturation, odd forms
    send_text("F:100\n");
    send_text("B:-5\n");
    send_text("L: +32767\n");
    send_text("R:99999999\n");
    send_text("S\n");
    send_text("Sxyz\n");
    send_text("E\n");
    send_text("E:7\n");
    send_text("D:-12,34\n");
    send_text("D:5\n");              // no comma, no word
    send_text("D:1,2,3\n");          // only the first comma splits
    send_text("\n");                 // empty line
    send_text("X:1\n");
    send_text("F5\n");
    send_text("D: -99999 , +99999\n");
    send_text("F:-\n");
    send_text("F:\t 7x8\n");
    send_text("B:+-3\n");
    // zero byte ends the text, later bytes ignored
    line_bytes.delete();
    put_str("F:1");
    line_bytes.push_back(smcp_pkg::CH_NUL);
    put_str("9\n");
    send_line();
    line_bytes.delete();
    line_bytes.push_back(smcp_pkg::CH_NUL);
    put_str("S\n");
    send_line();
    line_bytes.delete();
    line_bytes.push_back(8'hFF);
    put_str(":\n");
    send_line();
    // just under the buffer size, then over it
    line_bytes.delete();
    put_str("R:");
    repeat (61) line_bytes.push_back(8'h39);
    line_bytes.push_back(smcp_pkg::CH_NL);
    send_line();
    line_bytes.delete();
    put_str("F:");
    repeat (70) line_bytes.push_back(8'h31);
    line_bytes.push_back(smcp_pkg::CH_NL);
    send_line();

    // random lines
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!hold_done && bytes_sent >= 500) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      // final stretch runs without idling
      if (bytes_sent >= RANDOM_BYTES * 4 / 5)
        idle_on = 1'b0;
      build_line();
      send_line();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/smcp_pkg.sv
rtl/smcp_front.sv
rtl/smcp_queue.sv
rtl/smcp_back.sv
rtl/serial_motion_command_parser_top.sv
bench/smcp_command_checker.sv
bench/tb_serial_motion_command_parser_top.sv
